[rtl/hlcg_pkg.sv]
// Shared types and constants for the hex line cell generator.
package hlcg_pkg;

   localparam int CoordW     = 6;
   localparam int CellW      = 7;
   localparam int LenW       = 6;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One classified line request as it travels from the front end to the stepper.
   typedef struct packed {
      logic                           bad;
      logic [2:0][CoordW-1:0]         start;
      logic [2:0][CellW-1:0]          delta;
      logic [LenW-1:0]                len;
   } job_type;

endpackage

[rtl/hlcg_front.sv]
// Front end: checks the endpoints and forms the per-axis deltas and the hex distance.
module hlcg_front #(
   parameter int COORD_LIMIT = 31
) (
   input  logic signed [5:0]  start_q,
   input  logic signed [5:0]  start_r,
   input  logic signed [5:0]  start_s,
   input  logic signed [5:0]  end_q,
   input  logic signed [5:0]  end_r,
   input  logic signed [5:0]  end_s,
   output hlcg_pkg::job_type  job
);
   import hlcg_pkg::*;

   logic signed [CoordW-1:0] a [3];
   logic signed [CoordW-1:0] b [3];
   logic signed [CellW-1:0]  d [3];
   logic [CellW-1:0]         mag_a [3];
   logic [CellW-1:0]         mag_b [3];
   logic [CellW-1:0]         mag_d [3];
   logic signed [7:0]        sum_a;
   logic signed [7:0]        sum_b;
   logic [8:0]               dist2;
   logic                     range_bad;

   assign a[0] = start_q;
   assign a[1] = start_r;
   assign a[2] = start_s;
   assign b[0] = end_q;
   assign b[1] = end_r;
   assign b[2] = end_s;

   always_comb begin
      range_bad = 1'b0;
      for (int k = 0; k < 3; k++) begin
         mag_a[k] = a[k][CoordW-1] ? CellW'(-CellW'(a[k])) : CellW'(a[k]);
         mag_b[k] = b[k][CoordW-1] ? CellW'(-CellW'(b[k])) : CellW'(b[k]);
         d[k]     = CellW'(b[k]) - CellW'(a[k]);
         mag_d[k] = d[k][CellW-1] ? CellW'(-d[k]) : d[k];
         if (32'(mag_a[k]) > COORD_LIMIT || 32'(mag_b[k]) > COORD_LIMIT) begin
            range_bad = 1'b1;
         end
      end
   end

   assign sum_a = 8'(a[0]) + 8'(a[1]) + 8'(a[2]);
   assign sum_b = 8'(b[0]) + 8'(b[1]) + 8'(b[2]);
   assign dist2 = 9'(mag_d[0]) + 9'(mag_d[1]) + 9'(mag_d[2]);

   always_comb begin
      job.bad = range_bad || (sum_a != 8'sd0) || (sum_b != 8'sd0);
      for (int k = 0; k < 3; k++) begin
         job.start[k] = a[k];
         job.delta[k] = d[k];
      end
      // The three deltas of a valid line sum to zero, so half their magnitudes is the distance.
      job.len = dist2[LenW:1];
   end

endmodule

[rtl/hlcg_queue.sv]
// Small request queue between the front end and the line stepper.
module hlcg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hlcg_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output hlcg_pkg::job_type  head_job
);
   import hlcg_pkg::*;

   job_type               slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ptr_ff;
   logic [QueuePtrW-1:0]  wr_ptr_in;
   logic [QueuePtrW-1:0]  rd_ptr_ff;
   logic [QueuePtrW-1:0]  rd_ptr_in;
   logic [QueueCntW-1:0]  count_ff;
   logic [QueueCntW-1:0]  count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QueueDepth - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QueueDepth - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/hlcg_back.sv]
// Line stepper: walks one line a cell per cycle while rsp_stall is low and holds each cell in the output register.
module hlcg_back #(
   parameter int MAX_LINE_CELLS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  hlcg_pkg::job_type  job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [6:0]  rsp_cell_q,
   output logic signed [6:0]  rsp_cell_r,
   output logic signed [6:0]  rsp_cell_s,
   output logic [5:0]         rsp_step_index,
   output logic               rsp_last_cell,
   output logic               rsp_bad_input
);
   import hlcg_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                     state_ff;
   logic                     state_in;
   logic                     bad_ff;
   logic                     bad_in;
   logic signed [CellW-1:0]  delta_ff [3];
   logic signed [CellW-1:0]  delta_in [3];
   logic [LenW-1:0]          len_ff;
   logic [LenW-1:0]          len_in;
   logic [LenW-1:0]          den_ff;
   logic [LenW-1:0]          den_in;
   logic [LenW-1:0]          idx_ff;
   logic [LenW-1:0]          idx_in;
   // Each axis holds floor(num / den) and the remainder, with num = a*den + d*i.
   logic signed [CellW-1:0]  quo_ff [3];
   logic signed [CellW-1:0]  quo_in [3];
   logic [LenW-1:0]          rem_ff [3];
   logic [LenW-1:0]          rem_in [3];

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [CellW-1:0]  cell_ff [3];
   logic signed [CellW-1:0]  cell_in [3];
   logic [LenW-1:0]          rsp_idx_ff;
   logic [LenW-1:0]          rsp_idx_in;
   logic                     rsp_last_ff;
   logic                     rsp_last_in;
   logic                     rsp_bad_ff;
   logic                     rsp_bad_in;

   logic                     out_free;
   logic                     at_end;
   logic                     round_up [3];
   logic signed [CellW-1:0]  vround [3];
   logic signed [CellW-1:0]  vfix [3];
   logic [LenW-1:0]          err [3];
   logic signed [LenW+1:0]   rem_sum [3];
   logic signed [LenW+1:0]   den_ext;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_end   = (idx_ff == len_ff) || (32'(idx_ff) >= MAX_LINE_CELLS - 1);
   assign den_ext  = $signed({2'b00, den_ff});

   // Round each axis to nearest, halves away from zero, and measure the rounding error.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (quo_ff[k] < 0) begin
            round_up[k] = ({rem_ff[k], 1'b0} > {1'b0, den_ff});
         end else begin
            round_up[k] = ({rem_ff[k], 1'b0} >= {1'b0, den_ff});
         end
         vround[k] = round_up[k] ? quo_ff[k] + 7'sd1 : quo_ff[k];
         err[k]    = round_up[k] ? den_ff - rem_ff[k] : rem_ff[k];
         rem_sum[k] = $signed({2'b00, rem_ff[k]}) + (LenW+2)'(delta_ff[k]);
      end
   end

   // The axis with the largest error is rebuilt from the other two.
   always_comb begin
      vfix[0] = vround[0];
      vfix[1] = vround[1];
      vfix[2] = vround[2];
      if (err[0] > err[1] && err[0] > err[2]) begin
         vfix[0] = -vround[1] - vround[2];
      end else if (err[1] > err[2]) begin
         vfix[1] = -vround[0] - vround[2];
      end else begin
         vfix[2] = -vround[0] - vround[1];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bad_in       = bad_ff;
      len_in       = len_ff;
      den_in       = den_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      job_pop      = 1'b0;
      for (int k = 0; k < 3; k++) begin
         delta_in[k] = delta_ff[k];
         quo_in[k]   = quo_ff[k];
         rem_in[k]   = rem_ff[k];
         cell_in[k]  = cell_ff[k];
      end
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               state_in = ST_RUN;
               bad_in   = job.bad;
               len_in   = job.len;
               den_in   = (job.len == '0) ? LenW'(1) : job.len;
               idx_in   = '0;
               for (int k = 0; k < 3; k++) begin
                  delta_in[k] = $signed(job.delta[k]);
                  quo_in[k]   = CellW'($signed(job.start[k]));
                  rem_in[k]   = '0;
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bad_in   = bad_ff;
               rsp_last_in  = bad_ff || at_end;
               rsp_idx_in   = bad_ff ? '0 : idx_ff;
               for (int k = 0; k < 3; k++) begin
                  cell_in[k] = bad_ff ? '0 : vfix[k];
               end
               if (bad_ff || at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  // |delta| never exceeds den, so one correction keeps the remainder in range.
                  for (int k = 0; k < 3; k++) begin
                     if (rem_sum[k] >= den_ext) begin
                        rem_in[k] = LenW'(rem_sum[k] - den_ext);
                        quo_in[k] = quo_ff[k] + 7'sd1;
                     end else if (rem_sum[k] < 0) begin
                        rem_in[k] = LenW'(rem_sum[k] + den_ext);
                        quo_in[k] = quo_ff[k] - 7'sd1;
                     end else begin
                        rem_in[k] = LenW'(rem_sum[k]);
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff      <= bad_in;
      len_ff      <= len_in;
      den_ff      <= den_in;
      idx_ff      <= idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
      for (int k = 0; k < 3; k++) begin
         delta_ff[k] <= delta_in[k];
         quo_ff[k]   <= quo_in[k];
         rem_ff[k]   <= rem_in[k];
         cell_ff[k]  <= cell_in[k];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_q     = cell_ff[0];
   assign rsp_cell_r     = cell_ff[1];
   assign rsp_cell_s     = cell_ff[2];
   assign rsp_step_index = rsp_idx_ff;
   assign rsp_last_cell  = rsp_last_ff;
   assign rsp_bad_input  = rsp_bad_ff;

endmodule

[rtl/hex_line_cell_generator_core.sv]
// Top level of the hex line cell generator: front end, request queue and line stepper.
//
// A request carries a start and an end hex cell in cube coordinates. The block
// answers with every cell on the straight line between them, one response per
// cell, with its step index and a last-cell flag on the final one. Endpoints
// that do not sum to zero, or that hold a coordinate beyond COORD_LIMIT, give a
// single response with bad_input and last_cell set and all other fields zero.
// Lines longer than MAX_LINE_CELLS cells are cut to that many cells.
// A request is taken when req_valid is high and req_stall is low; req_stall is
// high only while the two-entry request queue is full.
// A taken request is written into the queue, loaded into the stepper once it is
// idle, and its first cell then enters the output register. The stepper produces
// one cell per cycle while rsp_stall is low; its single divide-free walk sets the rate.
// When rsp_stall is high the current cell holds on the outputs and the stepper
// waits; the queue keeps taking requests until it fills.
// Synchronous reset empties the queue and the output register and idles the
// stepper; no response is pending after reset.
module hex_line_cell_generator_core #(
   parameter int COORD_LIMIT    = 31,
   parameter int MAX_LINE_CELLS = 63
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [5:0]  req_start_q,
   input  logic signed [5:0]  req_start_r,
   input  logic signed [5:0]  req_start_s,
   input  logic signed [5:0]  req_end_q,
   input  logic signed [5:0]  req_end_r,
   input  logic signed [5:0]  req_end_s,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [6:0]  rsp_cell_q,
   output logic signed [6:0]  rsp_cell_r,
   output logic signed [6:0]  rsp_cell_s,
   output logic [5:0]         rsp_step_index,
   output logic               rsp_last_cell,
   output logic               rsp_bad_input
);
   import hlcg_pkg::*;

   job_type  front_job;
   job_type  head_job;
   logic     queue_full;
   logic     head_valid;
   logic     head_pop;

   assign req_stall = queue_full;

   hlcg_front #(
      .COORD_LIMIT (COORD_LIMIT)
   ) u_front (
      .start_q (req_start_q),
      .start_r (req_start_r),
      .start_s (req_start_s),
      .end_q   (req_end_q),
      .end_r   (req_end_r),
      .end_s   (req_end_s),
      .job     (front_job)
   );

   hlcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_job   (front_job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   hlcg_back #(
      .MAX_LINE_CELLS (MAX_LINE_CELLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job            (head_job),
      .job_pop        (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_q     (rsp_cell_q),
      .rsp_cell_r     (rsp_cell_r),
      .rsp_cell_s     (rsp_cell_s),
      .rsp_step_index (rsp_step_index),
      .rsp_last_cell  (rsp_last_cell),
      .rsp_bad_input  (rsp_bad_input)
   );

endmodule

[verif/hex_line_cell_generator_core_test.sv]
// Self-checking testbench for the hex line cell generator core.
`timescale 1ns / 1ps

module hex_line_cell_generator_core_test;

   localparam int CoordLimit   = 31;
   localparam int MaxLineCells = 63;
   localparam int IdlePercent  = 30;
   localparam int RandomCount  = 240;
   localparam int SettleCycles = 70;
   localparam int CycleLimit   = 300000;

   // Endpoints of one line request, held as plain integers.
   typedef struct {
      int from_c[3];
      int to_c[3];
   } hex_request_type;

   // One emitted cell, laid out in the same order as the response ports.
   typedef struct packed {
      logic signed [hlcg_pkg::CellW-1:0] q;
      logic signed [hlcg_pkg::CellW-1:0] r;
      logic signed [hlcg_pkg::CellW-1:0] s;
      logic [hlcg_pkg::LenW-1:0]         idx;
      logic                              last;
      logic                              bad;
   } line_cell_type;

   // A directed row either carries its single expected cell (q, r, s, index,
   // last, bad) or leaves the whole line to the predictor.
   typedef struct {
      hex_request_type rq;
      bit              typed;
      int              want[6];
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [5:0] req_start_q = '0;
   logic [5:0] req_start_r = '0;
   logic [5:0] req_start_s = '0;
   logic [5:0] req_end_q = '0;
   logic [5:0] req_end_r = '0;
   logic [5:0] req_end_s = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_cell_q;
   logic [6:0] rsp_cell_r;
   logic [6:0] rsp_cell_s;
   logic [5:0] rsp_step_index;
   logic       rsp_last_cell;
   logic       rsp_bad_input;

   logic          quiet = 1'b0;
   int            fail_count = 0;
   int            cycle_count = 0;
   line_cell_type cells_due[$];
   stim_row_type  directed_rows[20];

   hex_line_cell_generator_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_q    (req_start_q),
      .req_start_r    (req_start_r),
      .req_start_s    (req_start_s),
      .req_end_q      (req_end_q),
      .req_end_r      (req_end_r),
      .req_end_s      (req_end_s),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_q     (rsp_cell_q),
      .rsp_cell_r     (rsp_cell_r),
      .rsp_cell_s     (rsp_cell_s),
      .rsp_step_index (rsp_step_index),
      .rsp_last_cell  (rsp_last_cell),
      .rsp_bad_input  (rsp_bad_input)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int abs_of(int v);
      return (v < 0) ? -v : v;
   endfunction

   // Nearest integer to num / den for den > 0, halves rounded away from zero.
   function automatic int round_half_away(int num, int den);
      int q;
      q = (2 * abs_of(num) + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   // Appends one expected cell at the tail of the scoreboard.
   function automatic void queue_cell(line_cell_type c);
      cells_due = {cells_due, c};
   endfunction

   // Queues every cell that the block should emit for one accepted request.
   function automatic void plot_line_cells(hex_request_type rq);
      int            span[3];
      int            pos[3];
      int            miss[3];
      int            line_len, den, cells, num, i, k;
      bit            reject;
      line_cell_type c;
      reject = 1'b0;
      for (k = 0; k < 3; k++) begin
         if (abs_of(rq.from_c[k]) > CoordLimit || abs_of(rq.to_c[k]) > CoordLimit)
            reject = 1'b1;
      end
      if (rq.from_c[0] + rq.from_c[1] + rq.from_c[2] != 0 ||
          rq.to_c[0] + rq.to_c[1] + rq.to_c[2] != 0)
         reject = 1'b1;
      c = '0;
      if (reject) begin
         c.last = 1'b1;
         c.bad = 1'b1;
         queue_cell(c);
         return;
      end
      for (k = 0; k < 3; k++)
         span[k] = rq.to_c[k] - rq.from_c[k];
      line_len = (abs_of(span[0]) + abs_of(span[1]) + abs_of(span[2])) / 2;
      den = (line_len > 0) ? line_len : 1;
      cells = (line_len + 1 > MaxLineCells) ? MaxLineCells : line_len + 1;
      for (i = 0; i < cells; i++) begin
         for (k = 0; k < 3; k++) begin
            num = rq.from_c[k] * den + span[k] * i;
            pos[k] = round_half_away(num, den);
            miss[k] = abs_of(pos[k] * den - num);
         end
         // The coordinate that rounded worst is rebuilt from the other two;
         // q wins only on a strict maximum, then r only if it beats s strictly, else s.
         if (miss[0] > miss[1] && miss[0] > miss[2])
            pos[0] = -pos[1] - pos[2];
         else if (miss[1] > miss[2])
            pos[1] = -pos[0] - pos[2];
         else
            pos[2] = -pos[0] - pos[1];
         c.q = 7'(pos[0]);
         c.r = 7'(pos[1]);
         c.s = 7'(pos[2]);
         c.idx = 6'(i);
         c.last = (i == cells - 1);
         c.bad = 1'b0;
         queue_cell(c);
      end
   endfunction

   function automatic int random_coord6();
      int v;
      v = $urandom_range(0, 63);
      return (v > 31) ? v - 64 : v;
   endfunction

   // Picks a legal cube cell: q + r + s = 0 with every coordinate in range.
   function automatic void random_cell(output int c[3]);
      int lo, hi;
      c[0] = int'($urandom_range(0, 62)) - 31;
      lo = (c[0] > 0) ? -31 : -31 - c[0];
      hi = (c[0] > 0) ? 31 - c[0] : 31;
      c[1] = lo + int'($urandom_range(0, hi - lo));
      c[2] = -c[0] - c[1];
   endfunction

   function automatic hex_request_type random_request();
      hex_request_type rq;
      int              pick, k, dq, dr;
      pick = $urandom_range(0, 99);
      random_cell(rq.from_c);
      if (pick < 45) begin
         // Short lines keep many runs brief and exercise the rounding near ties.
         do begin
            dq = int'($urandom_range(0, 8)) - 4;
            dr = int'($urandom_range(0, 8)) - 4;
            rq.to_c[0] = rq.from_c[0] + dq;
            rq.to_c[1] = rq.from_c[1] + dr;
            rq.to_c[2] = -rq.to_c[0] - rq.to_c[1];
         end while (abs_of(rq.to_c[0]) > CoordLimit || abs_of(rq.to_c[1]) > CoordLimit ||
                    abs_of(rq.to_c[2]) > CoordLimit);
      end else begin
         random_cell(rq.to_c);
      end
      if (pick >= 88 && pick < 93) begin
         for (k = 0; k < 3; k++) begin
            rq.from_c[k] = random_coord6();
            rq.to_c[k] = random_coord6();
         end
      end else if (pick >= 93 && pick < 96) begin
         k = $urandom_range(0, 2);
         rq.to_c[k] = (rq.to_c[k] == 31) ? 30 : rq.to_c[k] + 1;
      end else if (pick >= 96) begin
         // Sums to zero yet holds a coordinate of -32.
         k = $urandom_range(1, 31);
         if (pick[0]) begin
            rq.from_c[0] = -32;
            rq.from_c[1] = k;
            rq.from_c[2] = 32 - k;
         end else begin
            rq.to_c[2] = -32;
            rq.to_c[0] = k;
            rq.to_c[1] = 32 - k;
         end
      end
      return rq;
   endfunction

   task automatic send_request(hex_request_type rq);
      req_valid <= 1'b1;
      req_start_q <= 6'(rq.from_c[0]);
      req_start_r <= 6'(rq.from_c[1]);
      req_start_s <= 6'(rq.from_c[2]);
      req_end_q <= 6'(rq.to_c[0]);
      req_end_r <= 6'(rq.to_c[1]);
      req_end_s <= 6'(rq.to_c[2]);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap();
      while (!quiet && $urandom_range(0, 99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      while (cells_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string what, line_cell_type want, line_cell_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s: expected q=%0d r=%0d s=%0d idx=%0d last=%0b bad=%0b",
                  $realtime, what, want.q, want.r, want.s, want.idx, want.last, want.bad);
         $display("%0t: %s: got      q=%0d r=%0d s=%0d idx=%0d last=%0b bad=%0b",
                  $realtime, what, got.q, got.r, got.s, got.idx, got.last, got.bad);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IdlePercent);
   end

   always @(posedge clock) begin : check_cells
      line_cell_type got, want;
      got = {rsp_cell_q, rsp_cell_r, rsp_cell_s, rsp_step_index, rsp_last_cell, rsp_bad_input};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cells_due.size() == 0) begin
            want = '0;
            report_mismatch("unexpected cell", want, got);
         end else begin
            want = cells_due.pop_front();
            if (got !== want)
               report_mismatch("cell mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      hex_request_type rq;
      line_cell_type   typed_cell;
      int              n;
      directed_rows = '{
         '{'{'{1, 0, 0}, '{0, 0, 0}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{0, 0, 0}, '{0, 0, -1}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{-32, 31, 1}, '{0, 0, 0}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{0, 0, 0}, '{16, -32, 16}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{-1, -1, -1}, '{-1, -1, -1}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{-32, -32, -32}, '{31, 31, 31}}, 1'b1, '{0, 0, 0, 0, 1, 1}},
         '{'{'{0, 0, 0}, '{0, 0, 0}}, 1'b1, '{0, 0, 0, 0, 1, 0}},
         '{'{'{31, -31, 0}, '{31, -31, 0}}, 1'b1, '{31, -31, 0, 0, 1, 0}},
         '{'{'{-31, 0, 31}, '{-31, 0, 31}}, 1'b1, '{-31, 0, 31, 0, 1, 0}},
         '{'{'{31, -31, 0}, '{-31, 31, 0}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{-31, 0, 31}, '{31, 0, -31}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{0, 31, -31}, '{0, -31, 31}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{31, 0, -31}, '{-31, 31, 0}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{0, 0, 0}, '{2, -1, -1}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{0, 0, 0}, '{-2, 1, 1}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{0, 0, 0}, '{1, 1, -2}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{0, 0, 0}, '{-1, 2, -1}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{5, -3, -2}, '{6, -3, -3}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{-5, 2, 3}, '{7, -10, 3}}, 1'b0, '{0, 0, 0, 0, 0, 0}},
         '{'{'{10, 10, -20}, '{-13, -7, 20}}, 1'b0, '{0, 0, 0, 0, 0, 0}}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].rq);
         if (directed_rows[i].typed) begin
            typed_cell.q = 7'(directed_rows[i].want[0]);
            typed_cell.r = 7'(directed_rows[i].want[1]);
            typed_cell.s = 7'(directed_rows[i].want[2]);
            typed_cell.idx = 6'(directed_rows[i].want[3]);
            typed_cell.last = directed_rows[i].want[4][0];
            typed_cell.bad = directed_rows[i].want[5][0];
            queue_cell(typed_cell);
         end else begin
            plot_line_cells(directed_rows[i].rq);
         end
         idle_gap();
      end
      await_drain();

      for (n = 0; n < RandomCount; n++) begin
         quiet <= (n >= 60 && n < 110);
         rq = random_request();
         send_request(rq);
         plot_line_cells(rq);
         if (n == 150)
            await_drain();
         else
            idle_gap();
      end
      quiet <= 1'b0;
      await_drain();
      repeat (SettleCycles) @(posedge clock);

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[hex_line_cell_generator_core.f]
rtl/hlcg_pkg.sv
rtl/hlcg_front.sv
rtl/hlcg_queue.sv
rtl/hlcg_back.sv
rtl/hex_line_cell_generator_core.sv
verif/hex_line_cell_generator_core_test.sv
